@@ src/psd3_pkg.sv @@
// Shared types and codes for the point to segment distance pipeline.
package psd3_pkg;

    // Code that tells which point of the segment is nearest to the query.
    typedef logic [1:0] t_kind;

    localparam t_kind KIND_FOOT  = 2'd0;
    localparam t_kind KIND_START = 2'd1;
    localparam t_kind KIND_END   = 2'd2;

endpackage

@@ src/psd3_div.sv @@
// Pipelined restoring divider that retires one quotient bit per stage.
module psd3_div #(
    parameter int NUM_W = 99,
    parameter int DEN_W = 67,
    parameter int QUO_W = 32
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    // Partial remainder and divisor travel with the quotient bits found so far.
    logic [NUM_W-1:0] r_rem [QUO_W-1];
    logic [DEN_W-1:0] r_den [QUO_W-1];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int K = QUO_W - 1 - j;

        logic [NUM_W-1:0] w_rem_in;
        logic [NUM_W-1:0] w_trial;
        logic [DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0] w_quo_in;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_den_in = r_den[j-1];
            assign w_quo_in = r_quo[j-1];
        end

        // The divisor scaled to this quotient bit is taken off when it fits.
        assign w_trial = NUM_W'(w_den_in) << K;
        assign w_ge    = (w_rem_in >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[j] <= w_ge ? (w_quo_in | (QUO_W'(1) << K)) : w_quo_in;
            end
        end

        if (j < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[j] <= w_den_in;
                    r_rem[j] <= w_ge ? (w_rem_in - w_trial) : w_rem_in;
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

@@ src/psd3_sqrt.sv @@
// Pipelined integer square root, truncated, one root bit per stage.
module psd3_sqrt #(
    parameter int RAD_W  = 66,
    parameter int ROOT_W = 33
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [RAD_W-1:0]  i_rad,
    output logic [ROOT_W-1:0] o_root
);

    localparam int TRW = RAD_W + 1;

    // The remainder holds the radicand less the square of the root so far.
    logic [RAD_W-1:0]  r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int B = ROOT_W - 1 - j;

        logic [RAD_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [TRW-1:0]    w_trial;
        logic              w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in  = i_rad;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
        end

        // Setting bit B grows the square by 2*root*2^B + 2^(2B).
        assign w_trial = (TRW'(w_root_in) << (B + 1)) | (TRW'(1) << (2 * B));
        assign w_ge    = (TRW'(w_rem_in) >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[j] <= w_ge ? (w_root_in | (ROOT_W'(1) << B)) : w_root_in;
            end
        end

        if (j < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? RAD_W'(TRW'(w_rem_in) - w_trial) : w_rem_in;
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

@@ src/point_segment_distance_3d_top.sv @@
// An accepted transaction passes the front stages, the dividers, the back stages, the root
// pipeline and the output register on its way to o_valid. Throughput: one transaction per
// cycle while o_stall is low; the quotient and root pipelines retire one bit per stage, and
// the output register with a skid stage keeps input and output apart. o_stall rises only
// while the skid stage holds a result. Reset is synchronous and active low; it clears every
// valid bit, payloads are not reset. There is no other state.
module point_segment_distance_3d_top
    import psd3_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_start_z,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_seg_end_z,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_query_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic        [COORD_WIDTH+1:0] o_distance,
    output logic signed [COORD_WIDTH-1:0] o_nearest_x,
    output logic signed [COORD_WIDTH-1:0] o_nearest_y,
    output logic signed [COORD_WIDTH-1:0] o_nearest_z,
    output t_kind                         o_nearest_kind
);

    localparam int CW  = COORD_WIDTH;
    localparam int VW  = CW + 1;              // coordinate difference
    localparam int PW  = 2 * VW;              // product of two differences
    localparam int NW  = PW + 2;              // signed dot product sum
    localparam int DW  = 2 * CW + 2;          // sum of three squares
    localparam int NCH = 3;                   // slices of the dot product
    localparam int CHW = (DW + NCH - 1) / NCH;
    localparam int PPW = CHW + CW;
    localparam int TW  = DW + CW + 1;         // rounded dividend
    localparam int QW  = CW;                  // foot offset magnitude
    localparam int RW  = CW + 1;              // root bits
    localparam int OW  = CW + 2;              // distance port width

    typedef struct packed {
        logic [2:0][CW-1:0] s;
        logic [2:0][CW-1:0] p;
        logic [2:0][CW-1:0] nend;
        logic [2:0]         vneg;
        logic               intr;
        t_kind              kind;
        logic [DW-1:0]      dend;
    } t_dside;

    typedef struct packed {
        logic [2:0][CW-1:0] n;
        t_kind              kind;
    } t_qside;

    logic w_en;
    logic r_skid_vld;

    // Valid bits of the front, quotient, back and root sections.
    logic [6:0]    r_fv;
    logic [QW-1:0] r_dvld;
    logic [3:0]    r_bv;
    logic [RW-1:0] r_qvld;

    // The whole pipeline moves unless the skid stage is occupied.
    assign w_en    = !r_skid_vld;
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv   <= '0;
            r_dvld <= '0;
            r_bv   <= '0;
            r_qvld <= '0;
        end else if (w_en) begin
            r_fv   <= {r_fv[5:0], i_valid};
            r_dvld <= {r_dvld[QW-2:0], r_fv[6]};
            r_bv   <= {r_bv[2:0], r_dvld[QW-1]};
            r_qvld <= {r_qvld[RW-2:0], r_bv[3]};
        end
    end

    // Stage 1: register the transaction.
    logic signed [CW-1:0] r_s1_s [3];
    logic signed [CW-1:0] r_s1_e [3];
    logic signed [CW-1:0] r_s1_p [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_s[0] <= i_seg_start_x;
            r_s1_s[1] <= i_seg_start_y;
            r_s1_s[2] <= i_seg_start_z;
            r_s1_e[0] <= i_seg_end_x;
            r_s1_e[1] <= i_seg_end_y;
            r_s1_e[2] <= i_seg_end_z;
            r_s1_p[0] <= i_query_x;
            r_s1_p[1] <= i_query_y;
            r_s1_p[2] <= i_query_z;
        end
    end

    // Stage 2: direction, start to query and end to query differences.
    logic signed [CW-1:0] r_s2_s [3];
    logic signed [CW-1:0] r_s2_e [3];
    logic signed [CW-1:0] r_s2_p [3];
    logic signed [VW-1:0] r_s2_v [3];
    logic signed [VW-1:0] r_s2_w [3];
    logic signed [VW-1:0] r_s2_u [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s2_s[i] <= r_s1_s[i];
                r_s2_e[i] <= r_s1_e[i];
                r_s2_p[i] <= r_s1_p[i];
                r_s2_v[i] <= VW'(r_s1_e[i]) - VW'(r_s1_s[i]);
                r_s2_w[i] <= VW'(r_s1_p[i]) - VW'(r_s1_s[i]);
                r_s2_u[i] <= VW'(r_s1_p[i]) - VW'(r_s1_e[i]);
            end
        end
    end

    // Stage 3: all products per axis.
    logic signed [CW-1:0] r_s3_s  [3];
    logic signed [CW-1:0] r_s3_e  [3];
    logic signed [CW-1:0] r_s3_p  [3];
    logic signed [VW-1:0] r_s3_v  [3];
    logic signed [PW-1:0] r_s3_wv [3];
    logic signed [PW-1:0] r_s3_vv [3];
    logic signed [PW-1:0] r_s3_ww [3];
    logic signed [PW-1:0] r_s3_uu [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_s[i]  <= r_s2_s[i];
                r_s3_e[i]  <= r_s2_e[i];
                r_s3_p[i]  <= r_s2_p[i];
                r_s3_v[i]  <= r_s2_v[i];
                r_s3_wv[i] <= r_s2_w[i] * r_s2_v[i];
                r_s3_vv[i] <= r_s2_v[i] * r_s2_v[i];
                r_s3_ww[i] <= r_s2_w[i] * r_s2_w[i];
                r_s3_uu[i] <= r_s2_u[i] * r_s2_u[i];
            end
        end
    end

    // Stage 4: projection numerator, squared length and squared endpoint distances.
    logic signed [CW-1:0] r_s4_s [3];
    logic signed [CW-1:0] r_s4_e [3];
    logic signed [CW-1:0] r_s4_p [3];
    logic signed [VW-1:0] r_s4_v [3];
    logic signed [NW-1:0] r_s4_num;
    logic [DW-1:0]        r_s4_den;
    logic [DW-1:0]        r_s4_d0;
    logic [DW-1:0]        r_s4_d1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s4_s[i] <= r_s3_s[i];
                r_s4_e[i] <= r_s3_e[i];
                r_s4_p[i] <= r_s3_p[i];
                r_s4_v[i] <= r_s3_v[i];
            end
            r_s4_num <= NW'(r_s3_wv[0]) + NW'(r_s3_wv[1]) + NW'(r_s3_wv[2]);
            r_s4_den <= DW'(r_s3_vv[0][2*CW-1:0]) + DW'(r_s3_vv[1][2*CW-1:0])
                      + DW'(r_s3_vv[2][2*CW-1:0]);
            r_s4_d0  <= DW'(r_s3_ww[0][2*CW-1:0]) + DW'(r_s3_ww[1][2*CW-1:0])
                      + DW'(r_s3_ww[2][2*CW-1:0]);
            r_s4_d1  <= DW'(r_s3_uu[0][2*CW-1:0]) + DW'(r_s3_uu[1][2*CW-1:0])
                      + DW'(r_s3_uu[2][2*CW-1:0]);
        end
    end

    // Stage 5: interior test and choice of the nearer endpoint (start wins a tie).
    logic   w_s4_intr;
    logic   w_s4_pick_s;
    t_dside w_s4_side;

    assign w_s4_intr   = (r_s4_den != '0) && !r_s4_num[NW-1]
                      && (r_s4_num[NW-2:0] <= (NW-1)'(r_s4_den));
    assign w_s4_pick_s = (r_s4_d0 <= r_s4_d1);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s4_side.s[i]    = r_s4_s[i];
            w_s4_side.p[i]    = r_s4_p[i];
            w_s4_side.nend[i] = w_s4_pick_s ? r_s4_s[i] : r_s4_e[i];
            w_s4_side.vneg[i] = r_s4_v[i][VW-1];
        end
        w_s4_side.intr = w_s4_intr;
        if (w_s4_intr) begin
            w_s4_side.kind = KIND_FOOT;
        end else if (w_s4_pick_s) begin
            w_s4_side.kind = KIND_START;
        end else begin
            w_s4_side.kind = KIND_END;
        end
        w_s4_side.dend = w_s4_pick_s ? r_s4_d0 : r_s4_d1;
    end

    t_dside        r_s5_side;
    logic [DW-1:0] r_s5_numu;
    logic [DW-1:0] r_s5_den;
    logic [CW-1:0] r_s5_vmag [3];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_side <= w_s4_side;
            r_s5_numu <= r_s4_num[DW-1:0];
            r_s5_den  <= r_s4_den;
            for (int i = 0; i < 3; i++) begin
                r_s5_vmag[i] <= r_s4_v[i][VW-1] ? CW'(-r_s4_v[i]) : CW'(r_s4_v[i]);
            end
        end
    end

    // Stage 6: slice products of numerator and direction magnitude.
    logic [NCH*CHW-1:0] w_s5_numx;
    t_dside             r_s6_side;
    logic [DW-1:0]      r_s6_den;
    logic [PPW-1:0]     r_s6_pp [3][NCH];

    assign w_s5_numx = (NCH*CHW)'(r_s5_numu);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_side <= r_s5_side;
            r_s6_den  <= r_s5_den;
            for (int i = 0; i < 3; i++) begin
                for (int c = 0; c < NCH; c++) begin
                    r_s6_pp[i][c] <= PPW'(w_s5_numx[c*CHW +: CHW]) * PPW'(r_s5_vmag[i]);
                end
            end
        end
    end

    // Stage 7: dividend 2*num*|v| + den for a round-half-up quotient by 2*den.
    logic [TW-1:0] w_s6_prod [3];
    t_dside        r_s7_side;
    logic [DW:0]   r_s7_den2;
    logic [TW-1:0] r_s7_t [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_s6_prod[i] = '0;
            for (int c = 0; c < NCH; c++) begin
                w_s6_prod[i] = w_s6_prod[i] + (TW'(r_s6_pp[i][c]) << (c * CHW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s7_side <= r_s6_side;
            r_s7_den2 <= {r_s6_den, 1'b0};
            for (int i = 0; i < 3; i++) begin
                r_s7_t[i] <= (w_s6_prod[i] << 1) + TW'(r_s6_den);
            end
        end
    end

    // Foot offsets, one divider per axis; the sideband keeps pace beside them.
    logic [QW-1:0] w_quo [3];
    t_dside        r_dside [QW];

    for (genvar g = 0; g < 3; g++) begin : g_div
        psd3_div #(
            .NUM_W (TW),
            .DEN_W (DW + 1),
            .QUO_W (QW)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_s7_t[g]),
            .i_den (r_s7_den2),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dside[0] <= r_s7_side;
            for (int k = 1; k < QW; k++) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    // Stage 8: nearest point, the foot or the chosen endpoint.
    t_dside               w_ds;
    logic signed [VW-1:0] w_off  [3];
    logic signed [VW-1:0] w_sext [3];
    logic signed [CW-1:0] r_s8_n [3];
    logic signed [CW-1:0] r_s8_p [3];
    logic                 r_s8_intr;
    t_kind                r_s8_kind;
    logic [DW-1:0]        r_s8_dend;

    assign w_ds = r_dside[QW-1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_off[i]  = $signed({1'b0, w_quo[i]});
            w_sext[i] = VW'($signed(w_ds.s[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_ds.intr) begin
                    r_s8_n[i] <= w_ds.vneg[i] ? CW'(w_sext[i] - w_off[i])
                                              : CW'(w_sext[i] + w_off[i]);
                end else begin
                    r_s8_n[i] <= $signed(w_ds.nend[i]);
                end
                r_s8_p[i] <= $signed(w_ds.p[i]);
            end
            r_s8_intr <= w_ds.intr;
            r_s8_kind <= w_ds.kind;
            r_s8_dend <= w_ds.dend;
        end
    end

    // Stage 9: query minus the nearest point, the foot or the chosen endpoint.
    logic signed [CW-1:0] r_s9_n [3];
    logic signed [VW-1:0] r_s9_d [3];
    logic                 r_s9_intr;
    t_kind                r_s9_kind;
    logic [DW-1:0]        r_s9_dend;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s9_n[i] <= r_s8_n[i];
                r_s9_d[i] <= VW'(r_s8_p[i]) - VW'(r_s8_n[i]);
            end
            r_s9_intr <= r_s8_intr;
            r_s9_kind <= r_s8_kind;
            r_s9_dend <= r_s8_dend;
        end
    end

    // Stage 10: squares of the query differences.
    logic signed [CW-1:0] r_s10_n  [3];
    logic signed [PW-1:0] r_s10_sq [3];
    logic                 r_s10_intr;
    t_kind                r_s10_kind;
    logic [DW-1:0]        r_s10_dend;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s10_n[i]  <= r_s9_n[i];
                r_s10_sq[i] <= r_s9_d[i] * r_s9_d[i];
            end
            r_s10_intr <= r_s9_intr;
            r_s10_kind <= r_s9_kind;
            r_s10_dend <= r_s9_dend;
        end
    end

    // Stage 11: squared distance for the root pipeline.
    t_qside        r_s11_side;
    logic [DW-1:0] r_s11_dsq;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s11_side.n[i] <= r_s10_n[i];
            end
            r_s11_side.kind <= r_s10_kind;
            r_s11_dsq <= r_s10_intr
                ? DW'(r_s10_sq[0][2*CW-1:0]) + DW'(r_s10_sq[1][2*CW-1:0])
                  + DW'(r_s10_sq[2][2*CW-1:0])
                : r_s10_dend;
        end
    end

    // Distance root with its sideband.
    logic [RW-1:0] w_root;
    t_qside        r_qside [RW];

    psd3_sqrt #(
        .RAD_W  (DW),
        .ROOT_W (RW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_s11_dsq),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qside[0] <= r_s11_side;
            for (int k = 1; k < RW; k++) begin
                r_qside[k] <= r_qside[k-1];
            end
        end
    end

    // Output register with a skid stage behind it.
    logic          w_lv;
    logic          w_out_free;
    logic          r_out_vld;
    logic [OW-1:0] r_out_dist;
    t_qside        r_out_side;
    logic [OW-1:0] r_skid_dist;
    t_qside        r_skid_side;

    assign w_lv       = r_qvld[RW-1];
    assign w_out_free = !r_out_vld || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= w_lv;
            end
        end else if (w_lv && w_en) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_vld) begin
                r_out_dist <= r_skid_dist;
                r_out_side <= r_skid_side;
            end else begin
                r_out_dist <= OW'(w_root);
                r_out_side <= r_qside[RW-1];
            end
        end else if (w_en) begin
            r_skid_dist <= OW'(w_root);
            r_skid_side <= r_qside[RW-1];
        end
    end

    assign o_valid        = r_out_vld;
    assign o_distance     = r_out_dist;
    assign o_nearest_x    = $signed(r_out_side.n[0]);
    assign o_nearest_y    = $signed(r_out_side.n[1]);
    assign o_nearest_z    = $signed(r_out_side.n[2]);
    assign o_nearest_kind = r_out_side.kind;

    // The skid stage is only ever filled behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid stage holds a result while the output register is empty");

    // A finished result arriving at a stalled output must land in the skid stage.
    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_stall && w_lv && !r_skid_vld) |=> r_skid_vld)
        else $error("result lost at a stalled output");

    // Draining the skid stage refills the output register and frees the pipeline.
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_stall) |=> (r_out_vld && !r_skid_vld))
        else $error("skid stage did not drain into the output register");

endmodule
